### hw/rtl/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication: when a holds, b must hold.
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
// Next-cycle implication: when a holds, b must hold in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif

`endif

### hw/rtl/skmt_pkg.sv
package skmt_pkg;

    typedef struct packed {
        logic       has_byte;
        logic [7:0] rx_byte;
        logic [7:0] elapsed_ms;
        logic [3:0] query_row;
    } slot_t;

    typedef struct packed {
        logic       modified;
        logic       send_disable_mouse;
        logic       led_level;
        logic [7:0] key_count;
        logic [7:0] row_bits;
        logic [1:0] phase_out;
    } result_t;

    // Keyboard phase
    localparam logic [1:0] PHASE_STARTUP = 2'd0;
    localparam logic [1:0] PHASE_IDLE    = 2'd1;
    localparam logic [1:0] PHASE_ACTIVE  = 2'd2;

    // Byte codes
    localparam logic [7:0] CODE_IGNORE_MIN = 8'hF6;
    localparam logic [7:0] CODE_STATUS_MIN = 8'hF0;

    // Blink periods in milliseconds
    localparam logic [12:0] PERIOD_RESET   = 13'd50;
    localparam logic [12:0] PERIOD_IDLE    = 13'd500;
    localparam logic [12:0] PERIOD_ACTIVE  = 13'd1000;
    localparam logic [12:0] PERIOD_BYTE    = 13'd200;
    localparam logic [12:0] PERIOD_NORMAL  = 13'd5000;
    localparam logic [12:0] PERIOD_NOMOUSE = 13'd100;

    // Sequencer
    typedef logic [2:0] step_t;

    localparam step_t STEP_WAIT   = 3'd0;
    localparam step_t STEP_DECODE = 3'd1;
    localparam step_t STEP_KEY    = 3'd2;
    localparam step_t STEP_BLINK  = 3'd3;
    localparam step_t STEP_QUERY  = 3'd4;
    localparam step_t STEP_EMIT   = 3'd5;
    localparam step_t STEP_WRAP   = 3'd6;

    typedef enum logic [2:0] {
        COND_NEVER    = 3'd0,
        COND_NO_SLOT  = 3'd1,
        COND_OVER     = 3'd2,
        COND_OUT_BUSY = 3'd3,
        COND_ALWAYS   = 3'd4
    } cond_t;

    typedef struct packed {
        logic  take;
        logic  decode;
        logic  rd_key;
        logic  key_wr;
        logic  blink;
        logic  rd_query;
        logic  emit;
        cond_t cond;
        step_t target;
    } ucode_t;

    typedef struct packed {
        logic slot_fire;
        logic over;
        logic out_busy;
    } cond_flags_t;

endpackage

### hw/rtl/skmt_ram.sv
module skmt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic                                  rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### hw/rtl/skmt_useq.sv
module skmt_useq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  skmt_pkg::cond_flags_t flags,
    output skmt_pkg::ucode_t      ctrl
);

    skmt_pkg::step_t step_reg;
    skmt_pkg::step_t step_next;
    logic            jump;

    function automatic skmt_pkg::ucode_t ucode_rom(input skmt_pkg::step_t s);
        skmt_pkg::ucode_t w;
        w        = '0;
        w.cond   = skmt_pkg::COND_NEVER;
        w.target = skmt_pkg::STEP_WAIT;
        case (s)
            skmt_pkg::STEP_WAIT:
            begin
                w.take   = 1'b1;
                w.cond   = skmt_pkg::COND_NO_SLOT;
                w.target = skmt_pkg::STEP_WAIT;
            end
            skmt_pkg::STEP_DECODE:
            begin
                w.decode = 1'b1;
                w.rd_key = 1'b1;
            end
            skmt_pkg::STEP_KEY:
            begin
                w.key_wr = 1'b1;
            end
            skmt_pkg::STEP_BLINK:
            begin
                w.blink  = 1'b1;
                w.cond   = skmt_pkg::COND_OVER;
                w.target = skmt_pkg::STEP_BLINK;
            end
            skmt_pkg::STEP_QUERY:
            begin
                w.rd_query = 1'b1;
            end
            skmt_pkg::STEP_EMIT:
            begin
                w.emit   = 1'b1;
                w.cond   = skmt_pkg::COND_OUT_BUSY;
                w.target = skmt_pkg::STEP_EMIT;
            end
            default:
            begin
                w.cond   = skmt_pkg::COND_ALWAYS;
                w.target = skmt_pkg::STEP_WAIT;
            end
        endcase
        return w;
    endfunction

    assign ctrl = ucode_rom(step_reg);

    always_comb
    begin
        case (ctrl.cond)
            skmt_pkg::COND_NO_SLOT:  jump = !flags.slot_fire;
            skmt_pkg::COND_OVER:     jump = flags.over;
            skmt_pkg::COND_OUT_BUSY: jump = flags.out_busy;
            skmt_pkg::COND_ALWAYS:   jump = 1'b1;
            default:                 jump = 1'b0;
        endcase
        step_next = jump ? ctrl.target : skmt_pkg::step_t'(step_reg + 3'd1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= skmt_pkg::STEP_WAIT;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

### hw/rtl/scancode_key_matrix_tracker.sv
// Channel   Direction  Handshake                Payload
// slot      in         slot_valid / slot_stall  slot   (skmt_pkg::slot_t)
// result    out        result_valid / result_stall result (skmt_pkg::result_t)
//
// An item passes the wait, decode, key, blink, query, emit and wrap steps of the
// sequencer; the blink step repeats, subtracting one LED period each time, while
// the count is above the period, and the wait step holds until a slot is taken.
// The result register frees the sequencer as soon as the result is loaded; a held
// result stalls only the emit step of the following item.
// Reset skips the row RAM; per-row valid flags make the key rows read as zero.
module scancode_key_matrix_tracker #(
    parameter int ROWS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              slot_valid,
    output logic              slot_stall,
    input  skmt_pkg::slot_t   slot,
    output logic              result_valid,
    input  logic              result_stall,
    output skmt_pkg::result_t result
);

`include "assert_macros.svh"

    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam logic [4:0] ROW_LIMIT = 5'(ROWS);
    localparam logic [7:0] KEYS_MAX = 8'(8 * ROWS);

    skmt_pkg::ucode_t      ctrl;
    skmt_pkg::cond_flags_t flags;

    skmt_pkg::slot_t   slot_reg;
    skmt_pkg::result_t result_reg;
    skmt_pkg::result_t result_next;
    logic              result_valid_reg;
    logic              result_valid_next;

    logic [1:0]  phase_reg;
    logic [1:0]  phase_next;
    logic [12:0] period_reg;
    logic [12:0] period_next;
    logic [13:0] count_reg;
    logic [13:0] count_next;
    logic        led_reg;
    logic        led_next;
    logic [7:0]  key_count_reg;
    logic [7:0]  key_count_next;
    logic [ROWS-1:0] row_valid_reg;
    logic [ROWS-1:0] row_valid_next;
    logic        mod_reg;
    logic        mod_next;
    logic        send_reg;
    logic        send_next;
    logic        key_act_reg;
    logic        key_act_next;

    logic             slot_fire;
    logic             out_busy;
    logic             emit_fire;
    logic             over;
    logic [3:0]       key_row;
    logic             key_row_ok;
    logic [ROW_W-1:0] key_addr;
    logic [ROW_W-1:0] q_addr;
    logic             q_ok;
    logic [7:0]       key_bit;
    logic [7:0]       cur_row;
    logic             wr_en;
    logic [7:0]       wr_data;
    logic             rd_en;
    logic [ROW_W-1:0] rd_addr;
    logic [7:0]       rd_data;

    skmt_useq u_useq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctrl  (ctrl)
    );

    skmt_ram #(
        .WIDTH (8),
        .DEPTH (ROWS)
    ) u_matrix (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (key_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign slot_stall   = !ctrl.take;
    assign slot_fire    = slot_valid && ctrl.take;
    assign out_busy     = result_valid_reg && result_stall;
    assign emit_fire    = ctrl.emit && !out_busy;
    assign over         = count_reg > {1'b0, period_reg};
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    assign flags.slot_fire = slot_fire;
    assign flags.over      = over;
    assign flags.out_busy  = out_busy;

    assign key_row    = slot_reg.rx_byte[6:3];
    assign key_row_ok = {1'b0, key_row} < ROW_LIMIT;
    assign key_addr   = key_row[ROW_W-1:0];
    assign q_addr     = slot_reg.query_row[ROW_W-1:0];
    assign q_ok       = {1'b0, slot_reg.query_row} < ROW_LIMIT;
    assign key_bit    = 8'(1) << slot_reg.rx_byte[2:0];
    assign rd_en      = ctrl.rd_key || ctrl.rd_query;
    assign rd_addr    = ctrl.rd_key ? key_addr : q_addr;
    assign cur_row    = (key_row_ok && row_valid_reg[key_addr]) ? rd_data : 8'd0;

    always_comb
    begin
        phase_next     = phase_reg;
        period_next    = period_reg;
        count_next     = count_reg;
        led_next       = led_reg;
        key_count_next = key_count_reg;
        row_valid_next = row_valid_reg;
        mod_next       = mod_reg;
        send_next      = send_reg;
        key_act_next   = key_act_reg;
        wr_en          = 1'b0;
        wr_data        = cur_row;

        if (ctrl.decode)
        begin
            send_next    = 1'b0;
            mod_next     = 1'b0;
            key_act_next = 1'b0;
            count_next   = count_reg + {6'd0, slot_reg.elapsed_ms};
            if (phase_reg == skmt_pkg::PHASE_STARTUP)
            begin
                if (slot_reg.has_byte)
                begin
                    phase_next = skmt_pkg::PHASE_IDLE;
                    if (slot_reg.rx_byte >= skmt_pkg::CODE_STATUS_MIN)
                    begin
                        period_next = skmt_pkg::PERIOD_NOMOUSE;
                        send_next   = 1'b1;
                    end
                    else
                    begin
                        period_next = skmt_pkg::PERIOD_NORMAL;
                    end
                end
            end
            else if (!slot_reg.has_byte)
            begin
                period_next = (phase_reg == skmt_pkg::PHASE_IDLE) ?
                              skmt_pkg::PERIOD_IDLE : skmt_pkg::PERIOD_ACTIVE;
                phase_next  = skmt_pkg::PHASE_IDLE;
            end
            else
            begin
                period_next = skmt_pkg::PERIOD_BYTE;
                if (slot_reg.rx_byte >= skmt_pkg::CODE_IGNORE_MIN)
                begin
                    phase_next = skmt_pkg::PHASE_IDLE;
                end
                else
                begin
                    phase_next   = skmt_pkg::PHASE_ACTIVE;
                    key_act_next = 1'b1;
                end
            end
        end

        // Row data from the read issued in the decode step arrives here
        if (ctrl.key_wr && key_act_reg && key_row_ok)
        begin
            if (slot_reg.rx_byte[7])
            begin
                if ((cur_row & key_bit) != 8'd0)
                begin
                    wr_en          = 1'b1;
                    wr_data        = cur_row & ~key_bit;
                    mod_next       = 1'b1;
                    key_count_next = key_count_reg - 8'd1;
                end
            end
            else if ((cur_row & key_bit) == 8'd0)
            begin
                wr_en          = 1'b1;
                wr_data        = cur_row | key_bit;
                mod_next       = 1'b1;
                key_count_next = key_count_reg + 8'd1;
            end
            if (wr_en)
            begin
                row_valid_next[key_addr] = 1'b1;
            end
        end

        // One period per cycle while the count is above it
        if (ctrl.blink && over)
        begin
            count_next = count_reg - {1'b0, period_reg};
            led_next   = ~led_reg;
        end
    end

    always_comb
    begin
        result_next                    = result_reg;
        result_next.modified           = mod_reg;
        result_next.send_disable_mouse = send_reg;
        result_next.led_level          = led_reg;
        result_next.key_count          = key_count_reg;
        result_next.row_bits           = (q_ok && row_valid_reg[q_addr]) ? rd_data : 8'd0;
        result_next.phase_out          = phase_reg;

        result_valid_next = result_valid_reg;
        if (emit_fire)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= skmt_pkg::PHASE_STARTUP;
            period_reg       <= skmt_pkg::PERIOD_RESET;
            count_reg        <= '0;
            led_reg          <= 1'b0;
            key_count_reg    <= '0;
            row_valid_reg    <= '0;
            mod_reg          <= 1'b0;
            send_reg         <= 1'b0;
            key_act_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg        <= phase_next;
            period_reg       <= period_next;
            count_reg        <= count_next;
            led_reg          <= led_next;
            key_count_reg    <= key_count_next;
            row_valid_reg    <= row_valid_next;
            mod_reg          <= mod_next;
            send_reg         <= send_next;
            key_act_reg      <= key_act_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (slot_fire)
        begin
            slot_reg <= slot;
        end
        if (emit_fire)
        begin
            result_reg <= result_next;
        end
    end

    `ASSERT_IMPLIES(a_key_count_max, clk, rst_n, 1'b1, key_count_reg <= KEYS_MAX)
    `ASSERT_NEXT(a_led_only_in_blink, clk, rst_n, !ctrl.blink, $stable(led_reg))
    `ASSERT_IMPLIES(a_count_settled, clk, rst_n, ctrl.emit, count_reg <= {1'b0, period_reg})

endmodule
